>>> src/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg: shared types and helpers for the circle overlap resolver
// Payload structs, fixed widths of the datapath, and the output clamp.
// ----------------------------------------------------------------------------
package cor_pkg;

    localparam int POS_W         = 24;           // signed Q12.F position
    localparam int RAD_W         = 20;           // unsigned Q8.F radius
    localparam int RSUM_W        = RAD_W + 1;    // radius sum
    localparam int MAG_W         = RSUM_W;       // clipped |dx|, |dy|
    localparam int SQ_W          = 2 * MAG_W;    // squared distance, overlap case
    localparam int ROOT_W        = SQ_W / 2;     // floor(sqrt) width
    localparam int REM_W         = ROOT_W + 3;   // sqrt partial remainder
    localparam int QUO_W         = RAD_W;        // correction magnitude < rsum/2
    localparam int DEN_W         = ROOT_W + 1;   // 2 * dist
    localparam int NUM_W         = MAG_W + RSUM_W;
    localparam int DREM_W        = DEN_W + 1;    // divider partial remainder
    localparam int CORR_W        = QUO_W + 2;    // signed correction
    localparam int SUM_W         = POS_W + 2;    // position +/- correction
    localparam int MID_DEPTH_DEF = 4;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic        [RAD_W-1:0] first_radius;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic        [RAD_W-1:0] second_radius;
    } cor_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_first_x;
        logic signed [POS_W-1:0] new_first_y;
        logic signed [POS_W-1:0] new_second_x;
        logic signed [POS_W-1:0] new_second_y;
        logic                    overlapped;
        logic                    coincident;
    } cor_out_t;

    // Per-item data that rides along the back-end pipeline
    typedef struct packed {
        logic signed [POS_W-1:0]  fx;
        logic signed [POS_W-1:0]  fy;
        logic signed [POS_W-1:0]  sx;
        logic signed [POS_W-1:0]  sy;
        logic                     neg_x;
        logic                     neg_y;
        logic        [MAG_W-1:0]  mag_x;
        logic        [MAG_W-1:0]  mag_y;
        logic        [RSUM_W-1:0] rsum;
        logic                     overlap;
    } cor_carry_t;

    // Classified item handed from front to back
    typedef struct packed {
        cor_carry_t            carry;
        logic     [SQ_W-1:0]   dist_sq;
    } cor_mid_t;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX[POS_W-1:0];
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/cor_front.sv
// ----------------------------------------------------------------------------
// cor_front: accept and classify
// Forms deltas and radius sum, squares them, and flags the overlap case.
// ----------------------------------------------------------------------------
module cor_front
    import cor_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cor_in_t  request,
    output logic     full,
    output logic     mid_push,
    output cor_mid_t mid_item,
    input  logic     mid_full
);

    logic                     en;
    logic                     s1_valid_reg;
    cor_carry_t               s1_reg;
    cor_carry_t               s1_next;
    logic                     s2_valid_reg;
    cor_carry_t               s2_reg;
    logic        [SQ_W-1:0]   s2_sqx_reg;
    logic        [SQ_W-1:0]   s2_sqy_reg;
    logic        [SQ_W-1:0]   s2_rsq_reg;
    logic signed [POS_W:0]    dx;
    logic signed [POS_W:0]    dy;
    logic        [POS_W:0]    adx;
    logic        [POS_W:0]    ady;
    logic        [SQ_W:0]     dist_sq;

    // whole front advances together unless the queue is full
    assign en   = !mid_full;
    assign full = !en;

    // stage 1: deltas, clipped magnitudes, radius sum
    always_comb
    begin
        dx  = (POS_W+1)'(request.second_x) - (POS_W+1)'(request.first_x);
        dy  = (POS_W+1)'(request.second_y) - (POS_W+1)'(request.first_y);
        adx = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
        ady = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
        s1_next.fx      = request.first_x;
        s1_next.fy      = request.first_y;
        s1_next.sx      = request.second_x;
        s1_next.sy      = request.second_y;
        s1_next.neg_x   = dx[POS_W];
        s1_next.neg_y   = dy[POS_W];
        // a magnitude past the radius-sum range can never overlap
        s1_next.mag_x   = (|adx[POS_W:MAG_W]) ? '1 : adx[MAG_W-1:0];
        s1_next.mag_y   = (|ady[POS_W:MAG_W]) ? '1 : ady[MAG_W-1:0];
        s1_next.rsum    = RSUM_W'(request.first_radius) + RSUM_W'(request.second_radius);
        s1_next.overlap = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s1_reg;
            s2_sqx_reg <= s1_reg.mag_x * s1_reg.mag_x;
            s2_sqy_reg <= s1_reg.mag_y * s1_reg.mag_y;
            s2_rsq_reg <= s1_reg.rsum * s1_reg.rsum;
        end
    end

    // sum and compare on the way into the queue
    always_comb
    begin
        dist_sq               = (SQ_W+1)'(s2_sqx_reg) + (SQ_W+1)'(s2_sqy_reg);
        mid_item.carry        = s2_reg;
        mid_item.carry.overlap = dist_sq < (SQ_W+1)'(s2_rsq_reg);
        mid_item.dist_sq      = dist_sq[SQ_W-1:0];
    end

    assign mid_push = s2_valid_reg && en;

endmodule

>>> src/cor_queue.sv
// ----------------------------------------------------------------------------
// cor_queue: short queue between front and back
// Register-based circular buffer of classified items.
// ----------------------------------------------------------------------------
module cor_queue
    import cor_pkg::*;
#(
    parameter int DEPTH = MID_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  cor_mid_t wr_item,
    output logic     full,
    input  logic     rd_en,
    output cor_mid_t rd_item,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cor_mid_t               mem_reg [DEPTH];
    logic     [PTR_W-1:0]   wr_ptr_reg;
    logic     [PTR_W-1:0]   rd_ptr_reg;
    logic     [CNT_W-1:0]   cnt_reg;
    logic     [CNT_W-1:0]   cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> src/cor_back.sv
// ----------------------------------------------------------------------------
// cor_back: correction datapath
// Pipelined square root (one bit per stage), products, pipelined divide
// (one quotient bit per stage), apply and clamp, two-entry result buffer.
// ----------------------------------------------------------------------------
module cor_back
    import cor_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cor_mid_t mid_item,
    input  logic     mid_empty,
    output logic     mid_pop,
    output logic     empty,
    input  logic     pop,
    output cor_out_t result
);

    logic                     en;

    // square root pipeline
    logic                     sq_valid_reg [ROOT_W];
    cor_carry_t               sq_carry_reg [ROOT_W];
    logic        [SQ_W-1:0]   sq_n_reg     [ROOT_W];
    logic        [REM_W-1:0]  sq_rem_reg   [ROOT_W];
    logic        [ROOT_W-1:0] sq_root_reg  [ROOT_W];

    // product stage
    logic                     pm_valid_reg;
    cor_carry_t               pm_carry_reg;
    logic                     pm_coinc_reg;
    logic        [DEN_W-1:0]  pm_den_reg;
    logic        [NUM_W-1:0]  pm_num_x_reg;
    logic        [NUM_W-1:0]  pm_num_y_reg;
    logic        [ROOT_W-1:0] root_val;
    logic        [RSUM_W-1:0] over_amt;

    // divide pipeline
    logic                     dv_valid_reg [QUO_W];
    cor_carry_t               dv_carry_reg [QUO_W];
    logic                     dv_coinc_reg [QUO_W];
    logic        [DEN_W-1:0]  dv_den_reg   [QUO_W];
    logic        [NUM_W-1:0]  dv_nx_reg    [QUO_W];
    logic        [NUM_W-1:0]  dv_ny_reg    [QUO_W];
    logic        [DREM_W-1:0] dv_rx_reg    [QUO_W];
    logic        [DREM_W-1:0] dv_ry_reg    [QUO_W];
    logic        [QUO_W-1:0]  dv_qx_reg    [QUO_W];
    logic        [QUO_W-1:0]  dv_qy_reg    [QUO_W];

    // result buffer
    cor_out_t                 ob_reg [2];
    logic                     ob_wr_reg;
    logic                     ob_rd_reg;
    logic        [1:0]        ob_cnt_reg;
    logic        [1:0]        ob_cnt_next;
    logic                     ob_push;
    logic                     ob_pop;
    cor_out_t                 fin;
    cor_carry_t               fc;
    logic signed [CORR_W-1:0] qxs;
    logic signed [CORR_W-1:0] qys;
    logic signed [CORR_W-1:0] cx;
    logic signed [CORR_W-1:0] cy;
    logic signed [CORR_W-1:0] push_amt;

    // whole back pipeline moves while the result buffer has room
    assign en      = (ob_cnt_reg != 2'd2);
    assign mid_pop = en && !mid_empty;

    // square root: stage i resolves root bit ROOT_W-1-i
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        logic                    v_in;
        cor_carry_t              c_in;
        logic       [SQ_W-1:0]   n_in;
        logic       [REM_W-1:0]  rem_in;
        logic       [ROOT_W-1:0] root_in;
        logic       [REM_W-1:0]  rem_sh;
        logic       [REM_W-1:0]  trial;
        logic                    take;

        if (i == 0)
        begin : g_first
            assign v_in    = mid_pop;
            assign c_in    = mid_item.carry;
            assign n_in    = mid_item.dist_sq;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[i-1];
            assign c_in    = sq_carry_reg[i-1];
            assign n_in    = sq_n_reg[i-1];
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], n_in[2*(ROOT_W-1-i)+1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_carry_reg[i] <= c_in;
                sq_n_reg[i]     <= n_in;
                sq_rem_reg[i]   <= take ? rem_sh - trial : rem_sh;
                sq_root_reg[i]  <= {root_in[ROOT_W-2:0], take};
            end
        end
    end

    // products: |d| * (rsum - root), divisor 2 * root
    assign root_val = sq_root_reg[ROOT_W-1];
    assign over_amt = sq_carry_reg[ROOT_W-1].rsum - RSUM_W'(root_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pm_valid_reg <= sq_valid_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_carry_reg <= sq_carry_reg[ROOT_W-1];
            pm_coinc_reg <= sq_carry_reg[ROOT_W-1].overlap && (root_val == '0);
            pm_den_reg   <= {root_val, 1'b0};
            pm_num_x_reg <= sq_carry_reg[ROOT_W-1].mag_x * over_amt;
            pm_num_y_reg <= sq_carry_reg[ROOT_W-1].mag_y * over_amt;
        end
    end

    // restoring divide: the quotient fits in QUO_W bits, so the upper part
    // of the numerator is already below the divisor
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic                    v_in;
        cor_carry_t              c_in;
        logic                    k_in;
        logic       [DEN_W-1:0]  den_in;
        logic       [NUM_W-1:0]  nx_in;
        logic       [NUM_W-1:0]  ny_in;
        logic       [DREM_W-1:0] rx_in;
        logic       [DREM_W-1:0] ry_in;
        logic       [QUO_W-1:0]  qx_in;
        logic       [QUO_W-1:0]  qy_in;
        logic       [DREM_W-1:0] rx_sh;
        logic       [DREM_W-1:0] ry_sh;
        logic                    tx;
        logic                    ty;

        if (j == 0)
        begin : g_first
            assign v_in   = pm_valid_reg;
            assign c_in   = pm_carry_reg;
            assign k_in   = pm_coinc_reg;
            assign den_in = pm_den_reg;
            assign nx_in  = pm_num_x_reg;
            assign ny_in  = pm_num_y_reg;
            assign rx_in  = DREM_W'(pm_num_x_reg[NUM_W-1:QUO_W]);
            assign ry_in  = DREM_W'(pm_num_y_reg[NUM_W-1:QUO_W]);
            assign qx_in  = '0;
            assign qy_in  = '0;
        end
        else
        begin : g_rest
            assign v_in   = dv_valid_reg[j-1];
            assign c_in   = dv_carry_reg[j-1];
            assign k_in   = dv_coinc_reg[j-1];
            assign den_in = dv_den_reg[j-1];
            assign nx_in  = dv_nx_reg[j-1];
            assign ny_in  = dv_ny_reg[j-1];
            assign rx_in  = dv_rx_reg[j-1];
            assign ry_in  = dv_ry_reg[j-1];
            assign qx_in  = dv_qx_reg[j-1];
            assign qy_in  = dv_qy_reg[j-1];
        end

        always_comb
        begin
            rx_sh = {rx_in[DREM_W-2:0], nx_in[QUO_W-1-j]};
            ry_sh = {ry_in[DREM_W-2:0], ny_in[QUO_W-1-j]};
            tx    = (rx_sh >= DREM_W'(den_in));
            ty    = (ry_sh >= DREM_W'(den_in));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_carry_reg[j] <= c_in;
                dv_coinc_reg[j] <= k_in;
                dv_den_reg[j]   <= den_in;
                dv_nx_reg[j]    <= nx_in;
                dv_ny_reg[j]    <= ny_in;
                dv_rx_reg[j]    <= tx ? rx_sh - DREM_W'(den_in) : rx_sh;
                dv_ry_reg[j]    <= ty ? ry_sh - DREM_W'(den_in) : ry_sh;
                dv_qx_reg[j]    <= {qx_in[QUO_W-2:0], tx};
                dv_qy_reg[j]    <= {qy_in[QUO_W-2:0], ty};
            end
        end
    end

    // apply correction and clamp
    always_comb
    begin
        fc       = dv_carry_reg[QUO_W-1];
        qxs      = signed'({2'b00, dv_qx_reg[QUO_W-1]});
        qys      = signed'({2'b00, dv_qy_reg[QUO_W-1]});
        push_amt = signed'({2'b00, fc.rsum[RSUM_W-1:1]});
        cx       = '0;
        cy       = '0;
        if (fc.overlap)
        begin
            if (dv_coinc_reg[QUO_W-1])
            begin
                cx = push_amt;
                cy = push_amt;
            end
            else
            begin
                cx = fc.neg_x ? -qxs : qxs;
                cy = fc.neg_y ? -qys : qys;
            end
        end
        fin.new_first_x  = sat_pos(SUM_W'(fc.fx) - SUM_W'(cx));
        fin.new_first_y  = sat_pos(SUM_W'(fc.fy) - SUM_W'(cy));
        fin.new_second_x = sat_pos(SUM_W'(fc.sx) + SUM_W'(cx));
        fin.new_second_y = sat_pos(SUM_W'(fc.sy) + SUM_W'(cy));
        fin.overlapped   = fc.overlap;
        fin.coincident   = dv_coinc_reg[QUO_W-1];
    end

    // two-entry result buffer
    assign ob_push = dv_valid_reg[QUO_W-1] && en;
    assign ob_pop  = pop && !empty;
    assign empty   = (ob_cnt_reg == 2'd0);
    assign result  = ob_reg[ob_rd_reg];

    always_comb
    begin
        ob_cnt_next = ob_cnt_reg;
        if (ob_push && !ob_pop)
        begin
            ob_cnt_next = ob_cnt_reg + 2'd1;
        end
        else if (ob_pop && !ob_push)
        begin
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
            if (ob_push)
            begin
                ob_wr_reg <= !ob_wr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= !ob_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= fin;
        end
    end

    // checks
    a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ob_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_coinc_implies_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!result.coincident || result.overlapped))
        else $error("coincident result without overlap");

    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> ob_cnt_reg != 2'd2)
        else $error("queue read while back end stalled");

    a_push_only_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        ob_push |=> ob_cnt_reg != 2'd0)
        else $error("result transfer lost");

endmodule

>>> src/circle_overlap_resolve.sv
// ----------------------------------------------------------------------------
// circle_overlap_resolve: two-circle overlap position correction
// Throughput: one pair per cycle while results are popped; the back end has
// a bit-per-stage square root and divider, so every stage takes a new item
// each cycle unless a full result buffer stalls the whole back end.
// Reset: asynchronous active-low; clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
module circle_overlap_resolve
    import cor_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  cor_in_t  request,
    output logic     empty,
    input  logic     pop,
    output cor_out_t result
);

    logic     mid_push;
    logic     mid_full;
    logic     mid_pop;
    logic     mid_empty;
    cor_mid_t mid_wr_item;
    cor_mid_t mid_rd_item;

    // classify
    cor_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .mid_push (mid_push),
        .mid_item (mid_wr_item),
        .mid_full (mid_full)
    );

    // decoupling queue
    cor_queue #(
        .DEPTH (MID_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_item (mid_wr_item),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_item (mid_rd_item),
        .empty   (mid_empty)
    );

    // correct
    cor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_rd_item),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> sim/circle_overlap_resolve_tb.sv
// ----------------------------------------------------------------------------
// circle_overlap_resolve_tb: self-checking bench for the overlap resolver
// Sends circle pairs through the push side and pops the corrected positions.
// A behavioral model predicts each result. Both sides idle at random, and
// one long pop stall fills the block.
// ----------------------------------------------------------------------------
module circle_overlap_resolve_tb;
    import cor_pkg::*;

    localparam int LATENCY = 45;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    cor_in_t  request;
    logic     empty;
    logic     pop;
    cor_out_t result;

    cor_out_t pending_fixes[$];
    int       errors;
    bit       pop_hold;      // long receiver stall while set
    bit       steady;        // no random idling while set

    circle_overlap_resolve uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Integer square root, floor
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [POS_W-1:0] clip(input longint v);
        logic signed [POS_W-1:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // Correction along one axis, truncated toward zero
    function automatic longint axis_shift(input longint d, input longint unsigned gap,
                                          input longint unsigned root_d);
        longint unsigned q;
        q = ((d < 0 ? -d : d) * gap) / (root_d * 2);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic cor_out_t resolve_pair(input cor_in_t c);
        cor_out_t        o;
        longint          fx, fy, sx, sy, dx, dy, cx, cy;
        longint unsigned rsum, dsq, root_d;
        fx = c.first_x;
        fy = c.first_y;
        sx = c.second_x;
        sy = c.second_y;
        dx = sx - fx;
        dy = sy - fy;
        rsum = longint'(c.first_radius) + longint'(c.second_radius);
        dsq = dx * dx + dy * dy;
        cx = 0;
        cy = 0;
        o.overlapped = 1'b0;
        o.coincident = 1'b0;
        if (dsq < rsum * rsum)
        begin
            root_d = floor_root(dsq);
            o.overlapped = 1'b1;
            if (root_d == 0)
            begin
                o.coincident = 1'b1;
                cx = rsum >> 1;
                cy = cx;
            end
            else
            begin
                cx = axis_shift(dx, rsum - root_d, root_d);
                cy = axis_shift(dy, rsum - root_d, root_d);
            end
        end
        o.new_first_x  = clip(fx - cx);
        o.new_first_y  = clip(fy - cy);
        o.new_second_x = clip(sx + cx);
        o.new_second_y = clip(sy + cy);
        return o;
    endfunction

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 21);
    endfunction

    // Offer one pair until the push transfer happens; push stays high
    // afterwards so back-to-back pairs need no gap
    task automatic send_pair(input cor_in_t c);
        while (idle_now())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= c;
        pending_fixes.push_back(resolve_pair(c));
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Pop side: random stalls, checks every transfer
    initial
    begin
        cor_out_t want;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_fixes.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = pending_fixes.pop_front();
                    if (result.new_first_x !== want.new_first_x)
                    begin
                        $display("%0t: new_first_x expected %0d actual %0d",
                                 $time, want.new_first_x, result.new_first_x);
                        errors++;
                    end
                    if (result.new_first_y !== want.new_first_y)
                    begin
                        $display("%0t: new_first_y expected %0d actual %0d",
                                 $time, want.new_first_y, result.new_first_y);
                        errors++;
                    end
                    if (result.new_second_x !== want.new_second_x)
                    begin
                        $display("%0t: new_second_x expected %0d actual %0d",
                                 $time, want.new_second_x, result.new_second_x);
                        errors++;
                    end
                    if (result.new_second_y !== want.new_second_y)
                    begin
                        $display("%0t: new_second_y expected %0d actual %0d",
                                 $time, want.new_second_y, result.new_second_y);
                        errors++;
                    end
                    if (result.overlapped !== want.overlapped)
                    begin
                        $display("%0t: overlapped expected %0b actual %0b",
                                 $time, want.overlapped, result.overlapped);
                        errors++;
                    end
                    if (result.coincident !== want.coincident)
                    begin
                        $display("%0t: coincident expected %0b actual %0b",
                                 $time, want.coincident, result.coincident);
                        errors++;
                    end
                end
            end
            pop <= !pop_hold && !idle_now();
        end
    end

    function automatic cor_in_t make_pair(input int fx, input int fy, input int fr,
                                          input int sx, input int sy, input int sr);
        cor_in_t c;
        c.first_x       = POS_W'(fx);
        c.first_y       = POS_W'(fy);
        c.first_radius  = RAD_W'(fr);
        c.second_x      = POS_W'(sx);
        c.second_y      = POS_W'(sy);
        c.second_radius = RAD_W'(sr);
        return c;
    endfunction

    function automatic int rand_pos();
        return int'($urandom_range(24'hFFFFFF)) - 8388608;
    endfunction

    // Extremes, coincidence, saturation, zero radii
    task automatic test_directed();
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 4096, 0, 0, 4096));
        send_pair(make_pair(1000, -1000, 1, 1000, -1000, 0));
        send_pair(make_pair(0, 0, 4096, 4096, 0, 4096));
        send_pair(make_pair(0, 0, 4096, 0, -4096, 4096));
        send_pair(make_pair(0, 0, 4096, 16384, 0, 4096));
        send_pair(make_pair(0, 0, 4096, 8192, 0, 0));
        send_pair(make_pair(8388607, 8388607, 20'hFFFFF, 8388607, 8388607, 20'hFFFFF));
        send_pair(make_pair(-8388608, -8388608, 20'hFFFFF, -8388608, -8388608,
                            20'hFFFFF));
        send_pair(make_pair(8388607, -8388608, 20'hFFFFF, 8388000, -8387000, 20'hFFFFF));
        send_pair(make_pair(-8388608, 8388607, 20'hFFFFF, 8388607, -8388608, 20'hFFFFF));
        send_pair(make_pair(8388607, 8388607, 20'hFFFFF, -8388608, -8388608, 20'hFFFFF));
        send_pair(make_pair(-8388608, 0, 20'hFFFFF, -8388608 + 1, 1, 20'hFFFFF));
        send_pair(make_pair(100, 100, 3, 101, 101, 0));
        send_pair(make_pair(0, 0, 20'hAAAAA, 5, -7, 20'h55555));
    endtask

    // Mostly overlapping pairs near each other, some anywhere
    task automatic test_random(input int count);
        cor_in_t c;
        int      span;
        repeat (count)
        begin
            c = make_pair(rand_pos(), rand_pos(), int'($urandom_range(20'hFFFFF)),
                          rand_pos(), rand_pos(), int'($urandom_range(20'hFFFFF)));
            if ($urandom_range(9) < 8)
            begin
                span = 1 << $urandom_range(22);
                c.second_x = POS_W'(c.first_x + int'($urandom_range(2 * span)) - span);
                c.second_y = POS_W'(c.first_y + int'($urandom_range(2 * span)) - span);
                if ($urandom_range(19) == 0)
                begin
                    c.second_x = c.first_x;
                    c.second_y = c.first_y;
                end
                if ($urandom_range(3) == 0)
                begin
                    c.first_radius  = RAD_W'($urandom_range(span));
                    c.second_radius = RAD_W'($urandom_range(span));
                end
            end
            send_pair(c);
        end
    endtask

    // Long pop stall while pairs keep coming, so full rises
    task automatic test_backpressure();
        pop_hold = 1'b1;
        fork
            test_random(120);
            begin
                repeat (300) @(posedge clk);
                pop_hold = 1'b0;
            end
        join
    endtask

    initial
    begin
        int waited;
        errors   = 0;
        pop_hold = 1'b0;
        steady   = 1'b0;
        rst_n    <= 1'b0;
        push     <= 1'b0;
        request  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(800);
        steady = 1'b1;
        test_random(300);
        steady = 1'b0;
        test_backpressure();
        test_random(700);
        push <= 1'b0;

        waited = 0;
        while (pending_fixes.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending_fixes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
